FILE: hw/rtl/dlle_pkg.sv
// Shared types and codes for the doubly linked list engine.
// No dependencies; the top level, dlle_store and dlle_ctrl import this package.
`default_nettype none
package dlle_pkg;

  localparam int DLLE_CAPACITY = 64;

  localparam logic [2:0] OP_FRONT  = 3'd0;
  localparam logic [2:0] OP_BACK   = 3'd1;
  localparam logic [2:0] OP_BEFORE = 3'd2;
  localparam logic [2:0] OP_AFTER  = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;
  localparam logic [2:0] OP_SEARCH = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CMP,
    S_LINK1,
    S_LINK2,
    S_DEL1,
    S_DEL2,
    S_DONE
  } state_t;

  // Write enables of the three node memories.
  typedef struct packed {
    logic value;
    logic nxt;
    logic prv;
  } wr_en_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [6:0] entry_count;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dlle_if.sv
// Request and response channel interfaces of the linked list engine.
// Depends on nothing; used by the top level.
`default_nettype none
interface dlle_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] new_value;
  logic signed [31:0] key;
  modport source (output valid, opcode, new_value, key, input ready);
  modport sink (input valid, opcode, new_value, key, output ready);
endinterface

interface dlle_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] position;
  logic [6:0] entry_count;
  modport source (output valid, status, position, entry_count, input ready);
  modport sink (input valid, status, position, entry_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/doubly_linked_list_engine_unit.sv
// Top level of the doubly linked list engine: sequencer, node memories and
// the response register. Uses dlle_pkg, dlle_if, dlle_ctrl and dlle_store.
//
//   channel  direction  carries
//   req      in         opcode, new_value, key
//   rsp      out        status, position, entry_count
//
// A request that names a key walks the list from the head, comparing one
// node at a time; the walk is bound by the single read port of the node
// memories. After reset a clearing pass over every node builds the free
// list and no request is taken meanwhile.
// Requests are taken one at a time; a finished response waits in its own
// register, and a stalled rsp holds the next response and new requests back.
`default_nettype none
module doubly_linked_list_engine_unit #(
  parameter int CAPACITY = dlle_pkg::DLLE_CAPACITY
) (
  input wire         clk,
  input wire         rst,
  dlle_req_if.sink   req,
  dlle_rsp_if.source rsp
);
  import dlle_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic               out_valid;
  logic               out_free;
  logic               res_load;
  rsp_t               res;
  rsp_t               out_data;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_value;
  logic [IW-1:0]      rd_next;
  logic [IW-1:0]      rd_prev;
  wr_en_t             we;
  logic [AW-1:0]      val_addr;
  logic signed [31:0] val_data;
  logic [AW-1:0]      nxt_addr;
  logic [IW-1:0]      nxt_data;
  logic [AW-1:0]      prv_addr;
  logic [IW-1:0]      prv_data;

  assign out_free = !out_valid || rsp.ready;

  dlle_ctrl #(.CAPACITY(CAPACITY), .IW(IW), .AW(AW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_opcode    (req.opcode),
    .in_new_value (req.new_value),
    .in_key       (req.key),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .rd_addr      (rd_addr),
    .rd_value     (rd_value),
    .rd_next      (rd_next),
    .rd_prev      (rd_prev),
    .we           (we),
    .val_addr     (val_addr),
    .val_data     (val_data),
    .nxt_addr     (nxt_addr),
    .nxt_data     (nxt_data),
    .prv_addr     (prv_addr),
    .prv_data     (prv_data)
  );

  dlle_store #(.CAPACITY(CAPACITY), .IW(IW), .AW(AW)) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_next  (rd_next),
    .rd_prev  (rd_prev),
    .we       (we),
    .val_addr (val_addr),
    .val_data (val_data),
    .nxt_addr (nxt_addr),
    .nxt_data (nxt_data),
    .prv_addr (prv_addr),
    .prv_data (prv_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      out_data <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_data.status;
  assign rsp.position    = out_data.position;
  assign rsp.entry_count = out_data.entry_count;

endmodule
`default_nettype wire

FILE: hw/rtl/dlle_store.sv
// Node memories: value, forward link and backward link, one write port each,
// one shared read address with registered read data. Uses dlle_pkg.
`default_nettype none
module dlle_store #(
  parameter int CAPACITY = 64,
  parameter int IW = 7,
  parameter int AW = 6
) (
  input  wire                      clk,
  input  wire  [AW-1:0]            rd_addr,
  output logic signed [31:0]       rd_value,
  output logic [IW-1:0]            rd_next,
  output logic [IW-1:0]            rd_prev,
  input  wire  dlle_pkg::wr_en_t   we,
  input  wire  [AW-1:0]            val_addr,
  input  wire  signed [31:0]       val_data,
  input  wire  [AW-1:0]            nxt_addr,
  input  wire  [IW-1:0]            nxt_data,
  input  wire  [AW-1:0]            prv_addr,
  input  wire  [IW-1:0]            prv_data
);
  import dlle_pkg::*;

  logic signed [31:0] value_mem [CAPACITY];
  logic [IW-1:0]      next_mem  [CAPACITY];
  logic [IW-1:0]      prev_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (we.value) begin
      value_mem[val_addr] <= val_data;
    end
    if (we.nxt) begin
      next_mem[nxt_addr] <= nxt_data;
    end
    if (we.prv) begin
      prev_mem[prv_addr] <= prv_data;
    end
    rd_value <= value_mem[rd_addr];
    rd_next  <= next_mem[rd_addr];
    rd_prev  <= prev_mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dlle_ctrl.sv
// Sequencer of the linked list engine: walks the list, takes and frees nodes
// and relinks neighbors through the node memories. Uses dlle_pkg.
`default_nettype none
module dlle_ctrl #(
  parameter int CAPACITY = 64,
  parameter int IW = 7,
  parameter int AW = 6
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [2:0]               in_opcode,
  input  wire  signed [31:0]       in_new_value,
  input  wire  signed [31:0]       in_key,
  input  wire                      out_free,
  output logic                     res_load,
  output dlle_pkg::rsp_t           res,
  output logic [AW-1:0]            rd_addr,
  input  wire  signed [31:0]       rd_value,
  input  wire  [IW-1:0]            rd_next,
  input  wire  [IW-1:0]            rd_prev,
  output dlle_pkg::wr_en_t         we,
  output logic [AW-1:0]            val_addr,
  output logic signed [31:0]       val_data,
  output logic [AW-1:0]            nxt_addr,
  output logic [IW-1:0]            nxt_data,
  output logic [AW-1:0]            prv_addr,
  output logic [IW-1:0]            prv_data
);
  import dlle_pkg::*;

  localparam logic [IW-1:0] NIL  = IW'(CAPACITY);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  state_t             state, state_next;
  logic [2:0]         op, op_next;
  logic signed [31:0] nv, nv_next;
  logic signed [31:0] key, key_next;
  logic [IW-1:0]      head, head_next;
  logic [IW-1:0]      tail, tail_next;
  logic [IW-1:0]      free_head, free_head_next;
  logic [IW-1:0]      len, len_next;
  logic [IW-1:0]      cur, cur_next;
  logic [IW-1:0]      cnt, cnt_next;
  logic [IW-1:0]      pos, pos_next;
  logic [IW-1:0]      nn, nn_next;
  logic [IW-1:0]      lp, lp_next;
  logic [IW-1:0]      lq, lq_next;
  logic [IW-1:0]      init_cnt, init_cnt_next;
  logic [1:0]         status, status_next;
  logic               start_alloc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      len       <= '0;
      init_cnt  <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      len       <= len_next;
      init_cnt  <= init_cnt_next;
    end
    op     <= op_next;
    nv     <= nv_next;
    key    <= key_next;
    cur    <= cur_next;
    cnt    <= cnt_next;
    pos    <= pos_next;
    nn     <= nn_next;
    lp     <= lp_next;
    lq     <= lq_next;
    status <= status_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    nv_next        = nv;
    key_next       = key;
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    len_next       = len;
    cur_next       = cur;
    cnt_next       = cnt;
    pos_next       = pos;
    nn_next        = nn;
    lp_next        = lp;
    lq_next        = lq;
    init_cnt_next  = init_cnt;
    status_next    = status;
    start_alloc    = 1'b0;
    in_ready       = 1'b0;
    res_load       = 1'b0;
    rd_addr        = cur[AW-1:0];
    we             = '0;
    val_addr       = nn[AW-1:0];
    val_data       = nv;
    nxt_addr       = nn[AW-1:0];
    nxt_data       = lq;
    prv_addr       = nn[AW-1:0];
    prv_data       = lp;

    case (state)
      S_INIT: begin
        // Chain every node onto the free list, one entry per cycle.
        we.nxt        = 1'b1;
        nxt_addr      = init_cnt[AW-1:0];
        nxt_data      = init_cnt + IW'(1);
        init_cnt_next = init_cnt + IW'(1);
        if (init_cnt == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next     = in_opcode;
          nv_next     = in_new_value;
          key_next    = in_key;
          status_next = ST_OK;
          pos_next    = '0;
          cnt_next    = '0;
          case (in_opcode)
            OP_FRONT: begin
              lp_next     = NIL;
              lq_next     = head;
              start_alloc = 1'b1;
            end
            OP_BACK: begin
              lp_next     = tail;
              lq_next     = NIL;
              start_alloc = 1'b1;
            end
            OP_BEFORE, OP_AFTER, OP_DELETE, OP_SEARCH: begin
              if (head == NIL) begin
                status_next = ST_NOTFOUND;
                state_next  = S_DONE;
              end else begin
                rd_addr    = head[AW-1:0];
                cur_next   = head;
                state_next = S_CMP;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_CMP: begin
        if (rd_value == key) begin
          case (op)
            OP_BEFORE: begin
              lp_next     = rd_prev;
              lq_next     = cur;
              start_alloc = 1'b1;
            end
            OP_AFTER: begin
              lp_next     = cur;
              lq_next     = rd_next;
              start_alloc = 1'b1;
            end
            OP_DELETE: begin
              lp_next    = rd_prev;
              lq_next    = rd_next;
              state_next = S_DEL1;
            end
            default: begin
              pos_next   = cnt + IW'(1);
              state_next = S_DONE;
            end
          endcase
        end else if (rd_next == NIL || cnt == LAST) begin
          status_next = ST_NOTFOUND;
          state_next  = S_DONE;
        end else begin
          // Follow the forward link straight into the next read.
          rd_addr  = rd_next[AW-1:0];
          cur_next = rd_next;
          cnt_next = cnt + IW'(1);
        end
      end
      S_LINK1: begin
        we.value       = 1'b1;
        we.nxt         = 1'b1;
        we.prv         = 1'b1;
        free_head_next = rd_next;
        len_next       = len + IW'(1);
        state_next     = S_LINK2;
      end
      S_LINK2: begin
        if (lp != NIL) begin
          we.nxt   = 1'b1;
          nxt_addr = lp[AW-1:0];
          nxt_data = nn;
        end else begin
          head_next = nn;
        end
        if (lq != NIL) begin
          we.prv   = 1'b1;
          prv_addr = lq[AW-1:0];
          prv_data = nn;
        end else begin
          tail_next = nn;
        end
        state_next = S_DONE;
      end
      S_DEL1: begin
        if (lp != NIL) begin
          we.nxt   = 1'b1;
          nxt_addr = lp[AW-1:0];
          nxt_data = lq;
        end else begin
          head_next = lq;
        end
        if (lq != NIL) begin
          we.prv   = 1'b1;
          prv_addr = lq[AW-1:0];
          prv_data = lp;
        end else begin
          tail_next = lp;
        end
        state_next = S_DEL2;
      end
      S_DEL2: begin
        we.nxt         = 1'b1;
        nxt_addr       = cur[AW-1:0];
        nxt_data       = free_head;
        free_head_next = cur;
        if (len != '0) begin
          len_next = len - IW'(1);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Taking a node reads its forward link to find the new free head.
    if (start_alloc) begin
      if (free_head == NIL) begin
        status_next = ST_FULL;
        state_next  = S_DONE;
      end else begin
        rd_addr    = free_head[AW-1:0];
        nn_next    = free_head;
        state_next = S_LINK1;
      end
    end
  end

  assign res.status      = status;
  assign res.position    = 7'(pos);
  assign res.entry_count = 7'(len);

endmodule
`default_nettype wire
